>>> hdl/wtws_pkg.sv
// Shared constants, types and the arctangent table for the waypoint to wheel speed block.
`timescale 1ns / 1ps
package wtws_pkg;

  localparam int XY_W  = 36;   // CORDIC x/y datapath width
  localparam int Z_W   = 35;   // CORDIC angle width, Q30 radians
  localparam int MUL_W = 34;   // shared multiplier operand width
  localparam int NUM_W = 96;   // dividend width
  localparam int DEN_W = 64;   // divisor width
  localparam int SPD_W = 31;   // wheel speed width
  localparam int CORDIC_STEPS = 31;

  localparam logic [Z_W-1:0]   PI_Q30   = 35'd3373259426;
  localparam logic [MUL_W-1:0] KINV_Q30 = 34'd652032874;
  localparam logic [SPD_W-1:0] SPD_MAX  = '1;

  typedef enum logic [2:0] {
    REG_RADIUS   = 3'd0,
    REG_HALF_WB  = 3'd1,
    REG_HEADING  = 3'd2,
    REG_START_X  = 3'd3,
    REG_START_Y  = 3'd4
  } reg_index_t;

  // start and completion pulses between the sequencer and a shared unit
  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic done;
  } unit_sts_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043836;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      default: r = 30'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

>>> hdl/wtws_cordic.sv
// Iterative vectoring CORDIC: one micro-rotation per cycle, gives magnitude and angle.
`timescale 1ns / 1ps
module wtws_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  wtws_pkg::unit_ctl_t           ctl,
  input  logic signed [wtws_pkg::XY_W-1:0] x0,
  input  logic signed [wtws_pkg::XY_W-1:0] y0,
  input  logic signed [wtws_pkg::Z_W-1:0]  z0,
  output wtws_pkg::unit_sts_t           sts,
  output logic [wtws_pkg::MUL_W-1:0]    xf,
  output logic signed [wtws_pkg::Z_W-1:0]  zf
);
  import wtws_pkg::*;

  logic signed [XY_W-1:0] x, y;
  logic signed [Z_W-1:0]  z;
  logic [4:0] i;
  logic busy;
  logic signed [XY_W-1:0] xs, ys;
  logic signed [Z_W-1:0]  ang;

  assign xs  = x >>> i;
  assign ys  = y >>> i;
  assign ang = $signed({5'd0, atan_q30(i)});
  assign xf  = x[MUL_W-1:0];
  assign zf  = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      sts.done <= 1'b0;
      i        <= '0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        x    <= x0;
        y    <= y0;
        z    <= z0;
        i    <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + ang;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - ang;
        end
        i <= i + 5'd1;
        if (i == 5'(CORDIC_STEPS - 1)) begin
          busy     <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> hdl/wtws_mul.sv
// Shift-add multiplier: one partial product added per cycle.
`timescale 1ns / 1ps
module wtws_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  wtws_pkg::unit_ctl_t          ctl,
  input  logic [wtws_pkg::MUL_W-1:0]   a,
  input  logic [wtws_pkg::MUL_W-1:0]   b,
  output wtws_pkg::unit_sts_t          sts,
  output logic [2*wtws_pkg::MUL_W-1:0] prod
);
  import wtws_pkg::*;

  logic [MUL_W-1:0] mcand;
  logic [2*MUL_W-1:0] acc;
  logic [MUL_W:0] upper;
  logic [5:0] cnt;
  logic busy;

  assign upper = {1'b0, acc[2*MUL_W-1:MUL_W]} + (acc[0] ? {1'b0, mcand} : '0);
  assign prod  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      sts.done <= 1'b0;
      cnt      <= '0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        mcand <= a;
        acc   <= {{MUL_W{1'b0}}, b};
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        acc <= {upper, acc[MUL_W-1:1]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(MUL_W - 1)) begin
          busy     <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> hdl/wtws_div.sv
// Restoring divider, one quotient bit per cycle, saturating quotient.
`timescale 1ns / 1ps
module wtws_div (
  input  logic                         clk,
  input  logic                         rst,
  input  wtws_pkg::unit_ctl_t          ctl,
  input  logic [wtws_pkg::NUM_W-1:0]   num,
  input  logic [wtws_pkg::DEN_W-1:0]   den,
  output wtws_pkg::unit_sts_t          sts,
  output logic [wtws_pkg::SPD_W-1:0]   quo
);
  import wtws_pkg::*;

  logic [NUM_W-1:0] dvd;
  logic [DEN_W-1:0] dvs, rem;
  logic [DEN_W:0] rem2;
  logic [SPD_W:0] q;
  logic ovf;
  logic [6:0] cnt;
  logic busy, take;

  assign rem2 = {rem, dvd[NUM_W-1]};
  assign take = rem2 >= {1'b0, dvs};
  assign quo  = (ovf || q[SPD_W]) ? SPD_MAX : q[SPD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      sts.done <= 1'b0;
      cnt      <= '0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        dvd  <= num;
        dvs  <= den;
        rem  <= '0;
        q    <= '0;
        ovf  <= 1'b0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        // quotient bits shifted past the top force saturation
        ovf <= ovf | q[SPD_W];
        q   <= {q[SPD_W-1:0], take};
        rem <= take ? DEN_W'(rem2 - {1'b0, dvs}) : rem2[DEN_W-1:0];
        dvd <= {dvd[NUM_W-2:0], 1'b0};
        cnt <= cnt + 7'd1;
        if (cnt == 7'(NUM_W - 1)) begin
          busy     <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> hdl/waypoint_to_wheel_speeds_top.sv
// Top level: waypoint to differential-drive wheel speeds, sequencer over shared units.
//
//  channel   dir  payload
//  s_*       in   tdata[31:0] target_x, tdata[63:32] target_y
//  m_*       out  tdata[30:0] right_speed, tdata[61:31] left_speed
//  wr_*      in   index 0..4 -> wheel_radius, half_wheelbase, start_heading, start_x, start_y
//
// One waypoint runs the normalizing shift s (0..31), the CORDIC, three multiplies and the
// bit-serial divider twice (96 steps each); the divider sets most of the run time.
// A repeated point skips normalization, CORDIC and the distance multiply.
// s_tready is high only while idle.
// A result waits in the output register under m_tready low; the next item is taken meanwhile.
// Reset is synchronous and loads the register defaults.
`timescale 1ns / 1ps
module waypoint_to_wheel_speeds_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // target_x, target_y
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // right_speed, left_speed, 2 zero bits
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data
);
  import wtws_pkg::*;

  localparam int SH = 30 - FRAC_BITS;
  localparam logic [MUL_W-1:0] C005 = MUL_W'(((64'd1 << FRAC_BITS) + 64'd10) / 64'd20);

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_CORD, S_VMUL, S_WMUL, S_DMUL, S_DIVR, S_DIVL, S_FIN
  } state_t;

  state_t state;

  logic [30:0] radius, half_wb;
  logic signed [31:0] prev_x, prev_y, prev_heading;

  logic [32:0] ax, ay, mx;
  logic dx_neg, dy_neg;
  logic [4:0] s;
  logic signed [33:0] w;
  logic [33:0] aw;
  logic [34:0] v;
  logic [65:0] lwm;
  logic [DEN_W-1:0] den;
  logic [SPD_W-1:0] right_spd, left_spd, right_out, left_out;

  // accept-time differences
  logic signed [32:0] dx_in, dy_in;
  logic [32:0] ax_in, ay_in;
  assign dx_in = $signed({s_tdata[31], s_tdata[31:0]}) - $signed({prev_x[31], prev_x});
  assign dy_in = $signed({s_tdata[63], s_tdata[63:32]}) - $signed({prev_y[31], prev_y});
  assign ax_in = dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
  assign ay_in = dy_in[32] ? 33'(-dy_in) : 33'(dy_in);

  // shared units
  unit_ctl_t cord_ctl, mul_ctl, div_ctl;
  unit_sts_t cord_sts, mul_sts, div_sts;
  logic signed [XY_W-1:0] cx0, cy0, ysg;
  logic signed [Z_W-1:0]  cz0, zf;
  logic [MUL_W-1:0] xf, mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  logic [NUM_W-1:0] num;
  logic [SPD_W-1:0] quo;

  assign cx0 = $signed({3'd0, ax});
  assign ysg = dy_neg ? -$signed({3'd0, ay}) : $signed({3'd0, ay});
  assign cy0 = dx_neg ? -ysg : ysg;
  assign cz0 = dx_neg ? (dy_neg ? -$signed(PI_Q30) : $signed(PI_Q30)) : '0;

  wtws_cordic u_cordic (
    .clk(clk), .rst(rst), .ctl(cord_ctl), .x0(cx0), .y0(cy0), .z0(cz0),
    .sts(cord_sts), .xf(xf), .zf(zf)
  );

  always_comb begin
    case (state)
      S_VMUL:  begin mul_a = xf;                    mul_b = KINV_Q30;            end
      S_WMUL:  begin mul_a = MUL_W'(half_wb);       mul_b = aw;                  end
      S_DMUL:  begin mul_a = MUL_W'(aw + C005);     mul_b = MUL_W'(radius);      end
      default: begin mul_a = '0;                    mul_b = '0;                  end
    endcase
  end

  wtws_mul u_mul (
    .clk(clk), .rst(rst), .ctl(mul_ctl), .a(mul_a), .b(mul_b), .sts(mul_sts), .prod(prod)
  );

  // dividend: 2.5 * |v*2^F +/- l*w|, scaled by 2^F
  logic signed [67:0] vsh, lws, sum_r, sum_l, sum_sel;
  logic [66:0] nmag;
  assign vsh     = $signed(68'(v) << FRAC_BITS);
  assign lws     = w[33] ? -$signed({2'b00, lwm}) : $signed({2'b00, lwm});
  assign sum_r   = vsh + lws;
  assign sum_l   = vsh - lws;
  assign sum_sel = (state == S_DIVL) ? sum_l : sum_r;
  assign nmag    = sum_sel[67] ? 67'(-sum_sel) : 67'(sum_sel);
  assign num     = (({29'd0, nmag} << 2) + {29'd0, nmag}) << (FRAC_BITS - 1);

  wtws_div u_div (
    .clk(clk), .rst(rst), .ctl(div_ctl), .num(num), .den(den), .sts(div_sts), .quo(quo)
  );

  // heading and distance after CORDIC / multiply
  logic signed [Z_W-1:0] zr;
  logic signed [31:0] theta;
  logic [65:0] vsum;
  assign zr    = zf + $signed(Z_W'(1) << (SH - 1));
  assign theta = 32'(zr >>> SH);
  assign vsum  = {2'b00, prod[63:0]} + (66'd1 << (29 + s));

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {2'b00, left_out, right_out};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      radius       <= 31'(64'd1 << FRAC_BITS);
      half_wb      <= 31'(64'd1 << FRAC_BITS);
      prev_x       <= '0;
      prev_y       <= '0;
      prev_heading <= '0;
      cord_ctl     <= '0;
      mul_ctl      <= '0;
      div_ctl      <= '0;
    end else begin
      cord_ctl <= '0;
      mul_ctl  <= '0;
      div_ctl  <= '0;
      if (m_tvalid && m_tready && state != S_FIN) m_tvalid <= 1'b0;

      if (wr_en) begin
        case (wr_index)
          REG_RADIUS:  radius  <= wr_data[30:0];
          REG_HALF_WB: half_wb <= wr_data[30:0];
          REG_HEADING: prev_heading <= 32'($signed(wr_data[18:0]));
          REG_START_X: prev_x <= $signed(wr_data);
          REG_START_Y: prev_y <= $signed(wr_data);
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ax     <= ax_in;
            ay     <= ay_in;
            mx     <= (ax_in > ay_in) ? ax_in : ay_in;
            dx_neg <= dx_in[32];
            dy_neg <= dy_in[32];
            s      <= '0;
            prev_x <= $signed(s_tdata[31:0]);
            prev_y <= $signed(s_tdata[63:32]);
            if (ax_in == '0 && ay_in == '0) begin
              // same point: heading and distance are zero
              w            <= -$signed({{2{prev_heading[31]}}, prev_heading});
              aw           <= prev_heading[31] ? 34'(-$signed({{2{prev_heading[31]}}, prev_heading}))
                                               : 34'(prev_heading);
              prev_heading <= '0;
              v            <= '0;
              mul_ctl.start <= 1'b1;
              state        <= S_WMUL;
            end else begin
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (mx[32:31] == 2'b00) begin
            ax <= ax << 1;
            ay <= ay << 1;
            mx <= mx << 1;
            s  <= s + 5'd1;
          end else begin
            cord_ctl.start <= 1'b1;
            state          <= S_CORD;
          end
        end
        S_CORD: begin
          if (cord_sts.done) begin
            w  <= 34'(theta) - 34'(prev_heading);
            aw <= ((34'(theta) - 34'(prev_heading)) & (34'd1 << 33)) != '0
                  ? 34'(34'(prev_heading) - 34'(theta)) : 34'(34'(theta) - 34'(prev_heading));
            prev_heading  <= theta;
            mul_ctl.start <= 1'b1;
            state         <= S_VMUL;
          end
        end
        S_VMUL: begin
          if (mul_sts.done) begin
            v             <= 35'(vsum >> (30 + s));
            mul_ctl.start <= 1'b1;
            state         <= S_WMUL;
          end
        end
        S_WMUL: begin
          if (mul_sts.done) begin
            lwm           <= prod[65:0];
            mul_ctl.start <= 1'b1;
            state         <= S_DMUL;
          end
        end
        S_DMUL: begin
          if (mul_sts.done) begin
            den           <= prod[DEN_W-1:0];
            div_ctl.start <= 1'b1;
            state         <= S_DIVR;
          end
        end
        S_DIVR: begin
          if (div_sts.done) begin
            right_spd     <= quo;
            div_ctl.start <= 1'b1;
            state         <= S_DIVL;
          end
        end
        S_DIVL: begin
          if (div_sts.done) begin
            left_spd <= quo;
            state    <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            right_out <= right_spd;
            left_out  <= left_spd;
            m_tvalid  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
